@@ src/http_header_tokenizer_core_macros.svh @@
// Assertion macros shared by the tokenizer checker.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef HTTP_HEADER_TOKENIZER_CORE_MACROS_SVH
`define HTTP_HEADER_TOKENIZER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define HTT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define HTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/htt_pkg.sv @@
// Types, constants and helper functions for the HTTP header tokenizer.
// No dependencies; used by every module of the block.
`default_nettype none

package htt_pkg;

    // Oversize limit on buffer offsets
    localparam int unsigned MAX_BUFFER = 65536;

    typedef enum logic [2:0] {
        KIND_METHOD = 3'd0,
        KIND_SEP    = 3'd1,
        KIND_EOL    = 3'd2,
        KIND_WORD   = 3'd3,
        KIND_HALT   = 3'd4,
        KIND_END    = 3'd5
    } kind_t;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    // Method names, first character in the top byte, zero padded
    localparam logic [63:0] METHOD_TEXT [8] = '{
        {"OPTIONS", 8'h00},
        {"GET",     40'h0},
        {"HEAD",    32'h0},
        {"POST",    32'h0},
        {"PUT",     40'h0},
        {"DELETE",  16'h0},
        {"TRACE",   24'h0},
        {"CONNECT", 8'h00}
    };
    localparam logic [2:0] METHOD_LEN [8] = '{
        3'd7, 3'd3, 3'd4, 3'd4, 3'd3, 3'd6, 3'd5, 3'd7
    };

    typedef struct packed {
        logic [7:0] byte_in;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [2:0]  method_code;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic        run_last;
    } out_item_t;

    // One token without its run marker
    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  code;
        logic [15:0] start;
        logic [15:0] len;
    } tok_t;

    // Up to three tokens caused by one byte
    typedef struct packed {
        tok_t [2:0] tok;
        logic [1:0] cnt;
    } bundle_t;

    typedef struct packed {
        logic [16:0] pos;
        logic        in_word;
        logic [15:0] word_begin;
        logic [15:0] word_count;
        logic [7:0]  cands;
        logic        cr_pending;
        logic        stopped;
        logic        first;
    } lex_state_t;

    localparam lex_state_t LEX_RESET = '{
        pos: 17'd0, in_word: 1'b0, word_begin: 16'd0, word_count: 16'd0,
        cands: 8'hFF, cr_pending: 1'b0, stopped: 1'b0, first: 1'b1
    };

    function automatic logic is_word_char(logic [7:0] c);
        return (c inside {["a":"z"], ["A":"Z"], ["0":"9"],
                          "/", ".", "-", "_", "+", "*", "=", ",", ";", "(", ")", "?"});
    endfunction

    function automatic logic [15:0] clamp16(logic [16:0] v);
        return v[16] ? 16'hFFFF : v[15:0];
    endfunction

    function automatic tok_t make_tok(kind_t kind, logic [2:0] code,
                                      logic [15:0] start, logic [15:0] len);
        tok_t t;
        t.kind  = kind;
        t.code  = code;
        t.start = start;
        t.len   = len;
        return t;
    endfunction

    // Append a token; a fourth one is dropped
    function automatic bundle_t push(bundle_t b, tok_t t);
        bundle_t r;
        r = b;
        case (b.cnt)
            2'd0:
            begin
                r.tok[0] = t;
                r.cnt    = 2'd1;
            end
            2'd1:
            begin
                r.tok[1] = t;
                r.cnt    = 2'd2;
            end
            2'd2:
            begin
                r.tok[2] = t;
                r.cnt    = 2'd3;
            end
            default:
            begin
                r = b;
            end
        endcase
        return r;
    endfunction

    // Narrow the method candidates by one more character
    function automatic logic [7:0] keep_cands(logic [7:0] cands, logic [15:0] wc,
                                              logic [7:0] c);
        logic [7:0] keep;
        logic [7:0] ch;
        keep = '0;
        for (int i = 0; i < 8; i++)
        begin
            ch = METHOD_TEXT[3'(i)][8 * (7 - int'(wc[2:0])) +: 8];
            keep[i] = cands[i] && (wc < 16'(METHOD_LEN[3'(i)])) && (ch == c);
        end
        return keep;
    endfunction

    // Method token for the first full match, else a word token
    function automatic tok_t word_token(logic [7:0] cands, logic [15:0] wc,
                                        logic [15:0] begin_pos);
        tok_t t;
        logic found;
        t = make_tok(KIND_WORD, 3'd0, begin_pos, wc);
        found = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (!found && cands[i] && (16'(METHOD_LEN[3'(i)]) == wc))
            begin
                t = make_tok(KIND_METHOD, 3'(i), begin_pos, wc);
                found = 1'b1;
            end
        end
        return t;
    endfunction

endpackage

`default_nettype wire

@@ src/htt_lexer.sv @@
// Lexer state and the single-pass step logic for one byte.
// Depends on htt_pkg.
`default_nettype none

module htt_lexer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire htt_pkg::in_item_t item,
    output htt_pkg::bundle_t      bundle
);

    htt_pkg::lex_state_t state_reg;
    htt_pkg::lex_state_t state_next;
    htt_pkg::lex_state_t s;
    htt_pkg::bundle_t    bnd;
    logic [16:0]         p;
    logic                used;

    // Compute the tokens and the next state for the held byte
    always_comb
    begin
        s    = state_reg;
        bnd  = '0;
        p    = state_reg.pos;
        used = 1'b0;

        if (!s.stopped)
        begin
            if (32'(p) >= htt_pkg::MAX_BUFFER)
            begin
                // Oversize: drop pending work and halt
                s.in_word    = 1'b0;
                s.cr_pending = 1'b0;
                bnd = htt_pkg::push(bnd, htt_pkg::make_tok(htt_pkg::KIND_HALT, 3'd0,
                                                           htt_pkg::clamp16(p), 16'd0));
                s.stopped = 1'b1;
            end
            else if (s.cr_pending)
            begin
                s.cr_pending = 1'b0;
                if (item.byte_in == htt_pkg::CHAR_LF)
                begin
                    bnd = htt_pkg::push(bnd, htt_pkg::make_tok(htt_pkg::KIND_EOL, 3'd0,
                                                               p[15:0] - 16'd1, 16'd2));
                    s.first = 1'b0;
                end
                else
                begin
                    bnd = htt_pkg::push(bnd, htt_pkg::make_tok(htt_pkg::KIND_HALT, 3'd0,
                                                               p[15:0] - 16'd1, 16'd0));
                    s.stopped = 1'b1;
                end
            end
            else
            begin
                // Extend or close the word in progress
                if (s.in_word)
                begin
                    if (htt_pkg::is_word_char(item.byte_in))
                    begin
                        s.cands = htt_pkg::keep_cands(s.cands, s.word_count, item.byte_in);
                        if (s.word_count != 16'hFFFF)
                            s.word_count = s.word_count + 16'd1;
                        used = 1'b1;
                    end
                    else
                    begin
                        bnd = htt_pkg::push(bnd, htt_pkg::word_token(s.cands, s.word_count,
                                                                     s.word_begin));
                        s.in_word = 1'b0;
                        s.first   = 1'b0;
                    end
                end

                // Classify a byte that starts something new
                if (!used)
                begin
                    if (item.byte_in == htt_pkg::CHAR_SPACE)
                    begin
                        if (s.first)
                        begin
                            bnd = htt_pkg::push(bnd, htt_pkg::make_tok(htt_pkg::KIND_HALT,
                                                               3'd0, p[15:0], 16'd0));
                            s.stopped = 1'b1;
                        end
                    end
                    else if (item.byte_in == htt_pkg::CHAR_COLON)
                    begin
                        bnd = htt_pkg::push(bnd, htt_pkg::make_tok(htt_pkg::KIND_SEP, 3'd0,
                                                                   p[15:0], 16'd1));
                        s.first = 1'b0;
                    end
                    else if (item.byte_in == htt_pkg::CHAR_CR)
                    begin
                        s.cr_pending = 1'b1;
                    end
                    else if (htt_pkg::is_word_char(item.byte_in))
                    begin
                        s.in_word    = 1'b1;
                        s.word_begin = p[15:0];
                        s.cands      = htt_pkg::keep_cands(8'hFF, 16'd0, item.byte_in);
                        s.word_count = 16'd1;
                    end
                    else
                    begin
                        bnd = htt_pkg::push(bnd, htt_pkg::make_tok(htt_pkg::KIND_HALT, 3'd0,
                                                                   p[15:0], 16'd0));
                        s.stopped = 1'b1;
                    end
                end
            end
        end

        // Flush at the last byte and restart for the next buffer
        if (item.final_byte)
        begin
            if (!s.stopped)
            begin
                if (s.in_word)
                    bnd = htt_pkg::push(bnd, htt_pkg::word_token(s.cands, s.word_count,
                                                                 s.word_begin));
                if (s.cr_pending)
                    bnd = htt_pkg::push(bnd, htt_pkg::make_tok(htt_pkg::KIND_HALT, 3'd0,
                                                               htt_pkg::clamp16(p), 16'd0));
            end
            bnd = htt_pkg::push(bnd, htt_pkg::make_tok(htt_pkg::KIND_END, 3'd0,
                                                       htt_pkg::clamp16(p + 17'd1), 16'd0));
            s = htt_pkg::LEX_RESET;
        end
        else if (!p[16])
        begin
            s.pos = p + 17'd1;
        end

        state_next = fire ? s : state_reg;
        bundle     = bnd;
    end

    // Advance the lexer state on each consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= htt_pkg::LEX_RESET;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

@@ src/htt_token_buf.sv @@
// Result register: holds the tokens of one byte and drains one per transfer.
// Depends on htt_pkg.
`default_nettype none

module htt_token_buf (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire htt_pkg::bundle_t   bundle,
    output logic                    free,
    output logic                    token_valid,
    input  wire logic               token_ready,
    output htt_pkg::out_item_t      token_item
);

    logic             valid_reg;
    logic             valid_next;
    logic [1:0]       idx_reg;
    logic [1:0]       idx_next;
    htt_pkg::bundle_t buf_reg;
    htt_pkg::tok_t    cur;
    logic             take;
    logic             last;

    assign cur  = buf_reg.tok[idx_reg];
    assign last = (idx_reg == (buf_reg.cnt - 2'd1));
    assign take = valid_reg && token_ready;
    assign free = !valid_reg || (take && last);

    // Present the current token
    always_comb
    begin
        token_valid             = valid_reg;
        token_item.token_kind   = cur.kind;
        token_item.method_code  = cur.code;
        token_item.token_start  = cur.start;
        token_item.token_length = cur.len;
        token_item.run_last     = last;
    end

    // Load a new bundle or step to the next token
    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = (bundle.cnt != 2'd0);
            idx_next   = 2'd0;
        end
        else if (take)
        begin
            if (last)
                valid_next = 1'b0;
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Hold the token payload
    always_ff @(posedge clk)
    begin
        if (load)
            buf_reg <= bundle;
    end

endmodule

`default_nettype wire

@@ src/http_header_tokenizer_core.sv @@
// HTTP header tokenizer: one header byte per transfer in, tokens out as kind, method code,
// start offset and length. A byte enters an input register, the lexer works on it once the
// result register is free and writes its tokens (zero to three) into that register, which
// drains one token per transfer; run_last marks the last token of a byte. While the token
// output is not stalled, a stream of bytes that cause at most one token each runs at one
// byte per cycle; a byte that causes more tokens holds the result register until they have
// drained through the single token output. A byte passes the input register and then the
// result register before its first token is offered.
// Depends on htt_pkg, htt_lexer and htt_token_buf.
`default_nettype none

module http_header_tokenizer_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_valid,
    output logic                    byte_ready,
    input  wire htt_pkg::in_item_t  byte_item,
    output logic                    token_valid,
    input  wire logic               token_ready,
    output htt_pkg::out_item_t      token_item
);

    logic              in_valid_reg;
    logic              in_valid_next;
    htt_pkg::in_item_t in_item_reg;
    logic              buf_free;
    logic              consume;
    htt_pkg::bundle_t  bundle;

    assign consume    = in_valid_reg && buf_free;
    assign byte_ready = !in_valid_reg || consume;

    // Track the input register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (byte_valid && byte_ready)
            in_valid_next = 1'b1;
        else if (consume)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // Capture the byte on transfer
    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
            in_item_reg <= byte_item;
    end

    htt_lexer u_lexer (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (consume),
        .item   (in_item_reg),
        .bundle (bundle)
    );

    htt_token_buf u_token_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (consume),
        .bundle      (bundle),
        .free        (buf_free),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token_item  (token_item)
    );

endmodule

`default_nettype wire

@@ src/htt_checker.sv @@
// Port-level checks on the tokenizer output, attached to the top level by bind.
// Depends on htt_pkg and http_header_tokenizer_core_macros.svh.
`default_nettype none

`include "http_header_tokenizer_core_macros.svh"

module htt_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               token_valid,
    input wire logic               token_ready,
    input wire htt_pkg::out_item_t token_item
);

    `HTT_ASSERT_NEXT(a_valid_hold, token_valid && !token_ready, token_valid, "token valid dropped while stalled")
    `HTT_ASSERT_NEXT(a_item_hold, token_valid && !token_ready, $stable(token_item), "token changed while stalled")
    `HTT_ASSERT_NOW(a_code_zero, token_valid && (token_item.token_kind != htt_pkg::KIND_METHOD), token_item.method_code == 3'd0, "method code set on a non-method token")
    `HTT_ASSERT_NOW(a_len_zero, token_valid && ((token_item.token_kind == htt_pkg::KIND_HALT) || (token_item.token_kind == htt_pkg::KIND_END)), token_item.token_length == 16'd0, "halt or end token with length")
    `HTT_ASSERT_NOW(a_end_last, token_valid && (token_item.token_kind == htt_pkg::KIND_END), token_item.run_last, "end token not last of its byte")

endmodule

bind http_header_tokenizer_core htt_checker u_htt_checker (.*);

`default_nettype wire
